>>> rtl/kfsp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// kfsp_pkg: shared types and constants of the free slot placer
// Field widths of the command and result words and the sequencer states.
// ============================================================================
package kfsp_pkg;

   localparam int SLOT_W  = 11;
   localparam int COUNT_W = 10;
   localparam int VALUE_W = 31;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_PLACE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_UPD_RD,
      ST_UPD_WR
   } state_type;

endpackage

>>> rtl/kth_free_slot_placer.sv
`timescale 1ns / 1ps
// ============================================================================
// kth_free_slot_placer: k-th free slot placer on a Fenwick tree
// Keeps free-slot counts in a Fenwick tree held in one memory and places
// each item into the lower-numbered of the k-th free slots from either end.
// ============================================================================
// A command word is taken at a rising edge with start high and busy low.
// A start word (req_type low) opens a run of req_slot_count slots, capped at MAX_SLOTS; a place
// word (req_type high) places req_item_value at rank req_taller_count + 1.
// Every command word gives exactly one result word, shown on the rsp_ ports
// for one cycle while rsp_valid is high; the receiver cannot stall it.
// A start word writes the tree one entry a cycle; an empty run writes
// nothing. A place word that cannot be placed is answered in the cycle
// after it is taken. Otherwise two Fenwick descents of L levels each, with
// L = clog2(MAX_SLOTS + 1), run on the tree memory with a read state and a
// compare-and-subtract state a level, and the update walks up to L nodes
// with a read and a write each.
// A new command word may be taken in the cycle in which a result is shown.
// Reset empties the run, so place words are impossible until a start word;
// the tree memory is not cleared, as a start word rewrites what it uses.
// ============================================================================
module kth_free_slot_placer
   import kfsp_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [SLOT_W-1:0]  req_slot_count,
   input  logic [COUNT_W-1:0] req_taller_count,
   input  logic [VALUE_W-1:0] req_item_value,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic [VALUE_W-1:0] rsp_placed_value,
   output logic               rsp_impossible
);

   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int KW = (SW > SLOT_W) ? SW : SLOT_W;
   localparam logic [SW-1:0] TOP_STEP = {1'b1, {(SW-1){1'b0}}};
   localparam logic [SW-1:0] ONE_STEP = SW'(1);

   function automatic logic [SW:0] low_bit(input logic [SW:0] x);
      low_bit = x & (~x + (SW+1)'(1));
   endfunction

   logic [SW-1:0] tree_mem [0:MAX_SLOTS];

   state_type state_ff, state_in;
   logic [SW-1:0] run_size_ff, run_size_in;
   logic [SW-1:0] placed_ff, placed_in;
   logic failed_ff, failed_in;
   logic [SW-1:0] pos_ff, pos_in;
   logic [SW-1:0] step_ff, step_in;
   logic [KW-1:0] rem_ff, rem_in;
   logic [KW-1:0] rem2_ff, rem2_in;
   logic second_ff, second_in;
   logic [SW-1:0] p1_ff, p1_in;
   logic [SW:0] idx_ff, idx_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [SW-1:0] rd_data_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_imp_ff, rsp_imp_in;

   logic mem_we, mem_re;
   logic [SW-1:0] mem_raddr, mem_wdata;

   logic accept;
   logic [KW-1:0] n_ext, rank;
   logic [SW-1:0] n_sat, free_cnt, next_pos, found;
   logic over, in_range, take, idx_ok, fill_done;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign n_ext     = KW'(req_slot_count);
   assign n_sat     = (n_ext > KW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : n_ext[SW-1:0];
   assign free_cnt  = run_size_ff - placed_ff;
   assign rank      = KW'(req_taller_count) + KW'(1);
   assign over      = rank > KW'(free_cnt);
   assign next_pos  = pos_ff + step_ff;
   assign in_range  = (next_pos <= run_size_ff);
   assign take      = in_range && (KW'(rd_data_ff) < rem_ff);
   assign found     = (take ? next_pos : pos_ff) + ONE_STEP;
   assign idx_ok    = (idx_ff <= {1'b0, run_size_ff});
   assign fill_done = (idx_ff == {1'b0, run_size_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_START) begin
                  state_in = (n_sat != '0) ? ST_FILL : ST_IDLE;
               end else if (!failed_ff && !over) begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_FILL: begin
            if (fill_done) state_in = ST_IDLE;
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            state_in = (step_ff == ONE_STEP && second_ff) ? ST_UPD_RD : ST_SRCH_RD;
         end
         ST_UPD_RD: state_in = idx_ok ? ST_UPD_WR : ST_IDLE;
         ST_UPD_WR: state_in = ST_UPD_RD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      run_size_in  = run_size_ff;
      placed_in    = placed_ff;
      failed_in    = failed_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      rem2_in      = rem2_ff;
      second_in    = second_ff;
      p1_in        = p1_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_slot_in  = rsp_slot_ff;
      rsp_value_in = rsp_value_ff;
      rsp_imp_in   = rsp_imp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff[SW-1:0];
      mem_wdata    = rd_data_ff - ONE_STEP;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_START) begin
                  run_size_in = n_sat;
                  placed_in   = '0;
                  failed_in   = 1'b0;
                  idx_in      = (SW+1)'(1);
                  if (n_sat == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_slot_in  = '0;
                     rsp_value_in = '0;
                     rsp_imp_in   = 1'b0;
                  end
               end else if (failed_ff || over) begin
                  failed_in    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_value_in = '0;
                  rsp_imp_in   = 1'b1;
               end else begin
                  value_in  = req_item_value;
                  rem_in    = rank;
                  rem2_in   = KW'(free_cnt) - rank + KW'(1);
                  pos_in    = '0;
                  step_in   = TOP_STEP;
                  second_in = 1'b0;
               end
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = SW'(low_bit(idx_ff));
            idx_in    = idx_ff + (SW+1)'(1);
            if (fill_done) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               rsp_value_in = '0;
               rsp_imp_in   = 1'b0;
            end
         end
         ST_SRCH_RD: begin
            mem_re    = in_range;
            mem_raddr = next_pos;
         end
         ST_SRCH_CMP: begin
            if (take) begin
               pos_in = next_pos;
               rem_in = rem_ff - KW'(rd_data_ff);
            end
            step_in = step_ff >> 1;
            if (step_ff == ONE_STEP) begin
               if (!second_ff) begin
                  p1_in     = found;
                  rem_in    = rem2_ff;
                  pos_in    = '0;
                  step_in   = TOP_STEP;
                  second_in = 1'b1;
               end else begin
                  p1_in  = (p1_ff < found) ? p1_ff : found;
                  idx_in = {1'b0, ((p1_ff < found) ? p1_ff : found)};
               end
            end
         end
         ST_UPD_RD: begin
            if (idx_ok) begin
               mem_re = 1'b1;
            end else begin
               placed_in    = placed_ff + ONE_STEP;
               rsp_valid_in = 1'b1;
               rsp_slot_in  = SLOT_W'(p1_ff);
               rsp_value_in = value_ff;
               rsp_imp_in   = 1'b0;
            end
         end
         ST_UPD_WR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + low_bit(idx_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[idx_ff[SW-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= tree_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_size_ff  <= '0;
         placed_ff    <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_size_ff  <= run_size_in;
         placed_ff    <= placed_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      rem_ff       <= rem_in;
      rem2_ff      <= rem2_in;
      second_ff    <= second_in;
      p1_ff        <= p1_in;
      idx_ff       <= idx_in;
      value_ff     <= value_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_imp_ff   <= rsp_imp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_placed_value = rsp_value_ff;
   assign rsp_impossible   = rsp_imp_ff;

`ifndef SYNTHESIS
   // An impossible word carries neither a slot nor a value.
   a_imp_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_impossible) |-> (rsp_slot_index == '0 && rsp_placed_value == '0))
      else $error("impossible result carries a slot or a value");

   // An accepted word either occupies the sequencer or is answered at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted word neither in progress nor answered");

   // The descent step is always a single power of two.
   a_step_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SRCH_RD || state_ff == ST_SRCH_CMP) |-> $onehot(step_ff))
      else $error("descent step is not a power of two");

   // Never more placements than slots in the run.
   a_placed_bound: assert property (@(posedge clock) disable iff (reset)
      placed_ff <= run_size_ff)
      else $error("placement count exceeds run size");

   // A successful placement always lands inside the run.
   a_slot_in_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_impossible && rsp_slot_index != '0)
         |-> (KW'(rsp_slot_index) <= KW'(run_size_ff)))
      else $error("placed slot lies outside the run");
`endif

endmodule

>>> verif/tb_kth_free_slot_placer.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_kth_free_slot_placer: self-checking testbench of the free slot placer
// Drives start and place words through the start/busy handshake with random
// gaps and checks every result word against a Fenwick tree predictor.
// ============================================================================
module tb_kth_free_slot_placer;
   import kfsp_pkg::*;

   localparam int MAX_SLOTS  = 1024;
   localparam int RAND_WORDS = 1250;

   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  count;
      logic [COUNT_W-1:0] taller;
      logic [VALUE_W-1:0] value;
   } cmd_word_t;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
      logic               impossible;
   } answer_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_type = REQ_START;
   logic [SLOT_W-1:0]  req_slot_count = '0;
   logic [COUNT_W-1:0] req_taller_count = '0;
   logic [VALUE_W-1:0] req_item_value = '0;
   logic               rsp_valid;
   logic [SLOT_W-1:0]  rsp_slot_index;
   logic [VALUE_W-1:0] rsp_placed_value;
   logic               rsp_impossible;

   cmd_word_t   cmd_q[$];
   answer_t     answer_q[$];
   cmd_word_t   cur_cmd;
   int unsigned total_words = 0;
   int unsigned words_sent = 0;
   int unsigned errors = 0;
   int unsigned runs_opened = 0;
   int unsigned slots_placed = 0;
   int unsigned words_refused = 0;

   int unsigned slot_tree [0:MAX_SLOTS];
   int unsigned run_len = 0;
   int unsigned placed_count = 0;
   bit          run_aborted = 1'b0;

   kth_free_slot_placer #(
      .MAX_SLOTS(MAX_SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_slot_count(req_slot_count),
      .req_taller_count(req_taller_count),
      .req_item_value(req_item_value),
      .rsp_valid(rsp_valid),
      .rsp_slot_index(rsp_slot_index),
      .rsp_placed_value(rsp_placed_value),
      .rsp_impossible(rsp_impossible)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #6_000_000;
      $display("tb_kth_free_slot_placer NOT OK");
      $finish;
   end

   function automatic int unsigned lowest_bit(int unsigned x);
      return x & (~x + 1);
   endfunction

   // Descends the tree to the rank-th free slot from the left.
   function automatic int unsigned find_free_slot(int unsigned rank);
      int unsigned step;
      int unsigned pos;
      int unsigned left;
      int unsigned nxt;
      step = 1;
      while (step * 2 <= MAX_SLOTS) step = step * 2;
      pos  = 0;
      left = rank;
      while (step != 0) begin
         nxt = pos + step;
         if (nxt <= run_len && slot_tree[nxt] < left) begin
            pos  = nxt;
            left = left - slot_tree[nxt];
         end
         step = step >> 1;
      end
      return pos + 1;
   endfunction

   function automatic void predict_answer(cmd_word_t c);
      answer_t     a;
      int unsigned n;
      int unsigned rank;
      int unsigned avail;
      int unsigned p1;
      int unsigned p2;
      int unsigned pick;
      int unsigned i;
      a = '0;
      if (c.kind == REQ_START) begin
         n = 32'(c.count);
         if (n > MAX_SLOTS) n = MAX_SLOTS;
         run_len      = n;
         placed_count = 0;
         run_aborted  = 1'b0;
         for (i = 1; i <= MAX_SLOTS; i++) slot_tree[i] = (i <= n) ? lowest_bit(i) : 0;
         runs_opened++;
      end else begin
         avail = (placed_count <= run_len) ? run_len - placed_count : 0;
         rank  = c.taller + 1;
         if (run_aborted || rank > avail) begin
            run_aborted  = 1'b1;
            a.impossible = 1'b1;
            words_refused++;
         end else begin
            p1   = find_free_slot(rank);
            p2   = find_free_slot(avail - rank + 1);
            pick = (p1 < p2) ? p1 : p2;
            i    = pick;
            while (i >= 1 && i <= run_len) begin
               slot_tree[i] = slot_tree[i] - 1;
               i = i + lowest_bit(i);
            end
            placed_count++;
            a.slot  = pick[SLOT_W-1:0];
            a.value = c.value;
            slots_placed++;
         end
      end
      answer_q.push_back(a);
   endfunction

   function automatic void queue_start(int unsigned n);
      cmd_word_t c;
      c       = '0;
      c.kind  = REQ_START;
      c.count = n[SLOT_W-1:0];
      c.value = VALUE_W'($urandom);
      cmd_q.push_back(c);
   endfunction

   function automatic void queue_place(int unsigned taller, logic [VALUE_W-1:0] value);
      cmd_word_t c;
      c        = '0;
      c.kind   = REQ_PLACE;
      c.count  = SLOT_W'($urandom);
      c.taller = taller[COUNT_W-1:0];
      c.value  = value;
      cmd_q.push_back(c);
   endfunction

   always @(posedge clock) begin : driver
      logic go;
      bit   calm;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go   = start;
         calm = (words_sent >= 500 && words_sent < 760);
         if (start && !busy) begin
            predict_answer(cur_cmd);
            words_sent++;
            go = 1'b0;
         end
         if (!go && cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
            cur_cmd          = cmd_q.pop_front();
            req_type         <= cur_cmd.kind;
            req_slot_count   <= cur_cmd.count;
            req_taller_count <= cur_cmd.taller;
            req_item_value   <= cur_cmd.value;
            go = 1'b1;
         end
         start <= go;
      end
   end

   always @(posedge clock) begin : monitor
      answer_t got;
      answer_t want;
      if (!reset && rsp_valid) begin
         got = '{rsp_slot_index, rsp_placed_value, rsp_impossible};
         if (answer_q.size() == 0) begin
            $display("%0t: result word with nothing expected: slot %0d value %0h imp %0b",
                     $time, got.slot, got.value, got.impossible);
            errors++;
         end else begin
            want = answer_q.pop_front();
            if (got.slot !== want.slot || got.value !== want.value
                || got.impossible !== want.impossible) begin
               $display("%0t: expected slot %0d value %0h imp %0b, got slot %0d value %0h imp %0b",
                        $time, want.slot, want.value, want.impossible,
                        got.slot, got.value, got.impossible);
               errors++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned n;
      int unsigned eff;
      int unsigned used;
      int unsigned len;
      int unsigned free;
      int unsigned c;
      int unsigned roll;
      logic [31:0] val;

      // Directed words: place before any start, empty and saturated runs,
      // overfilled and failed runs, and the extremes of every field.
      queue_place(0, 5);
      queue_start(0);
      queue_place(0, 7);
      queue_start(1);
      queue_place(0, 1);
      queue_place(0, 2);
      queue_place(0, 3);
      queue_start(2047);
      queue_place(1023, 0);
      queue_place(0, 100);
      queue_place(511, 31'h7FFF_FFFF);
      queue_place(1023, 31'h7FFF_FFFF);
      queue_start(1024);
      queue_place(1023, 31'h2AAA_AAAA);
      queue_start(1025);
      queue_place(0, 31'h5555_5555);
      queue_start(3);
      queue_place(2, 10);
      queue_place(1, 20);
      queue_place(0, 30);
      queue_place(0, 40);
      queue_start(6);
      queue_place(6, 50);
      queue_place(0, 60);
      queue_start(4);

      n = cmd_q.size() + RAND_WORDS;
      while (cmd_q.size() < n) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            if ($urandom_range(0, 3) == 0) queue_start($urandom_range(0, 48));
            else queue_place($urandom_range(0, 1023), VALUE_W'($urandom));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) eff = $urandom_range(1024, 2047);
            else if (roll < 9) eff = $urandom_range(41, 1023);
            else if (roll < 12) eff = 0;
            else eff = $urandom_range(1, 40);
            queue_start(eff);
            if (eff > MAX_SLOTS) eff = MAX_SLOTS;
            used = 0;
            len  = $urandom_range(1, ((eff < 40) ? eff : 40) + 2);
            val  = $urandom_range(0, 32'h7FF0_0000);
            repeat (len) begin
               free = eff - used;
               if (free > 1023 || (free != 0 && $urandom_range(0, 99) < 92)) begin
                  c = $urandom_range(0, free - 1);
                  used++;
               end else begin
                  c = $urandom_range(free, 1023);
               end
               val = val + $urandom_range(0, 4096);
               queue_place(c, val[VALUE_W-1:0]);
            end
         end
      end
      total_words = cmd_q.size();

      do @(posedge clock);
      while (words_sent < total_words || answer_q.size() != 0);
      repeat (100) @(posedge clock);
      if (answer_q.size() != 0) errors++;

      $display("Sent %0d words: %0d runs opened, %0d slots placed, %0d words refused.",
               words_sent, runs_opened, slots_placed, words_refused);
      $display("Mismatches found: %0d.", errors);
      if (errors == 0) begin
         $display("tb_kth_free_slot_placer OK");
      end else begin
         $display("tb_kth_free_slot_placer NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/kfsp_pkg.sv
rtl/kth_free_slot_placer.sv
verif/tb_kth_free_slot_placer.sv
